FILE: rtl/core/etl_pkg.sv
// ----------------------------------------------------------------------------
// etl_pkg
// Types, token kinds, lexer modes and character helpers for the expression
// token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package etl_pkg;

  localparam logic [4:0] KIND_END      = 5'd0;
  localparam logic [4:0] KIND_ERROR    = 5'd1;
  localparam logic [4:0] KIND_AND      = 5'd2;
  localparam logic [4:0] KIND_OR       = 5'd3;
  localparam logic [4:0] KIND_EQ       = 5'd4;
  localparam logic [4:0] KIND_NE       = 5'd5;
  localparam logic [4:0] KIND_GT       = 5'd6;
  localparam logic [4:0] KIND_GE       = 5'd7;
  localparam logic [4:0] KIND_LT       = 5'd8;
  localparam logic [4:0] KIND_LE       = 5'd9;
  localparam logic [4:0] KIND_STARTS   = 5'd10;
  localparam logic [4:0] KIND_ENDS     = 5'd11;
  localparam logic [4:0] KIND_PRESENT  = 5'd12;
  localparam logic [4:0] KIND_CONTAINS = 5'd13;
  localparam logic [4:0] KIND_PLUS     = 5'd14;
  localparam logic [4:0] KIND_MINUS    = 5'd15;
  localparam logic [4:0] KIND_MULT     = 5'd16;
  localparam logic [4:0] KIND_DIV      = 5'd17;
  localparam logic [4:0] KIND_MOD      = 5'd18;
  localparam logic [4:0] KIND_NOT      = 5'd19;
  localparam logic [4:0] KIND_FN       = 5'd20;
  localparam logic [4:0] KIND_LPAREN   = 5'd21;
  localparam logic [4:0] KIND_RPAREN   = 5'd22;
  localparam logic [4:0] KIND_VALUE    = 5'd23;
  localparam logic [4:0] KIND_COMMA    = 5'd24;
  localparam logic [4:0] KIND_NAME     = 5'd25;
  localparam logic [4:0] KIND_PID      = 5'd26;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'd0,
    MODE_BANG    = 5'd1,
    MODE_AMP     = 5'd2,
    MODE_STAR    = 5'd3,
    MODE_LESS    = 5'd4,
    MODE_EQUAL   = 5'd5,
    MODE_GREATER = 5'd6,
    MODE_CARET   = 5'd7,
    MODE_PIPE    = 5'd8,
    MODE_TILDE   = 5'd9,
    MODE_DOLLAR  = 5'd10,
    MODE_NAME    = 5'd11,
    MODE_BRACE   = 5'd12,
    MODE_QUOTE   = 5'd13,
    MODE_DIGITS  = 5'd14,
    MODE_SLASH   = 5'd15,
    MODE_TRUE    = 5'd16,
    MODE_FALSE   = 5'd17,
    MODE_VALUE   = 5'd18
  } lex_mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
    logic        overflow;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [4:0]  kind;
    logic [15:0] first;
    logic [15:0] stop;
  } emit_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_graph(input logic [7:0] b);
    return (b >= 8'd33) && (b <= 8'd126);
  endfunction

  function automatic logic is_name(input logic [7:0] b);
    return is_digit(b) || ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"))
           || (b == "_");
  endfunction

  function automatic logic [7:0] op_second(input lex_mode_t m);
    logic [7:0] c;
    case (m)
      MODE_AMP:  c = "&";
      MODE_PIPE: c = "|";
      default:   c = "=";
    endcase
    return c;
  endfunction

  function automatic logic [4:0] op_kind2(input lex_mode_t m);
    logic [4:0] k;
    case (m)
      MODE_BANG:    k = KIND_NE;
      MODE_AMP:     k = KIND_AND;
      MODE_STAR:    k = KIND_CONTAINS;
      MODE_LESS:    k = KIND_LE;
      MODE_EQUAL:   k = KIND_EQ;
      MODE_GREATER: k = KIND_GE;
      MODE_CARET:   k = KIND_STARTS;
      MODE_PIPE:    k = KIND_OR;
      MODE_TILDE:   k = KIND_PRESENT;
      default:      k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // rest of "true" / "false" after the first letter
  function automatic logic [7:0] lit_char(input logic is_false, input logic [2:0] idx);
    logic [7:0] c;
    if (is_false) begin
      case (idx)
        3'd0:    c = "a";
        3'd1:    c = "l";
        3'd2:    c = "s";
        3'd3:    c = "e";
        default: c = 8'd0;
      endcase
    end else begin
      case (idx)
        3'd0:    c = "r";
        3'd1:    c = "u";
        3'd2:    c = "e";
        default: c = 8'd0;
      endcase
    end
    return c;
  endfunction

  function automatic logic [15:0] span(input logic [15:0] first, input logic [15:0] stop);
    return (stop >= first) ? (stop - first) : 16'd0;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/etl_step.sv
// ----------------------------------------------------------------------------
// etl_step
// Lexer state and single-byte transition; produces up to two tokens per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module etl_step #(
  parameter logic [15:0] POS_LIMIT = 16'hFFFF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic [7:0]      text_byte,
  input  wire logic            end_of_text,
  output logic [1:0]           push_count,
  output etl_pkg::result_t     slot0,
  output etl_pkg::result_t     slot1
);
  import etl_pkg::*;

  typedef struct packed {
    logic       emit;
    logic [4:0] kind;
    lex_mode_t  mode;
    logic [4:0] pkind;
    logic       begin_next;
  } idle_t;

  function automatic idle_t idle_decode(input logic [7:0] b);
    idle_t d;
    d = '{emit: 1'b0, kind: KIND_ERROR, mode: MODE_IDLE, pkind: KIND_END, begin_next: 1'b0};
    if (is_space(b)) begin
      d.mode = MODE_IDLE;
    end else if (!is_graph(b)) begin
      d.emit = 1'b1;
      d.kind = KIND_ERROR;
    end else if (is_digit(b)) begin
      d.mode  = MODE_DIGITS;
      d.pkind = KIND_VALUE;
    end else begin
      case (b)
        "!":     begin d.mode = MODE_BANG;    d.pkind = KIND_NOT;   end
        "$":     begin d.mode = MODE_DOLLAR;  d.pkind = KIND_NAME;  end
        "%":     begin d.emit = 1'b1; d.kind = KIND_MOD;    end
        "(":     begin d.emit = 1'b1; d.kind = KIND_LPAREN; end
        ")":     begin d.emit = 1'b1; d.kind = KIND_RPAREN; end
        "+":     begin d.emit = 1'b1; d.kind = KIND_PLUS;   end
        ",":     begin d.emit = 1'b1; d.kind = KIND_COMMA;  end
        "-":     begin d.emit = 1'b1; d.kind = KIND_MINUS;  end
        "&":     begin d.mode = MODE_AMP;     d.pkind = KIND_ERROR; end
        "*":     begin d.mode = MODE_STAR;    d.pkind = KIND_MULT;  end
        "<":     begin d.mode = MODE_LESS;    d.pkind = KIND_LT;    end
        "=":     begin d.mode = MODE_EQUAL;   d.pkind = KIND_EQ;    end
        ">":     begin d.mode = MODE_GREATER; d.pkind = KIND_GT;    end
        "^":     begin d.mode = MODE_CARET;   d.pkind = KIND_ERROR; end
        "|":     begin d.mode = MODE_PIPE;    d.pkind = KIND_ERROR; end
        "~":     begin d.mode = MODE_TILDE;   d.pkind = KIND_ERROR; end
        "'":     begin d.mode = MODE_QUOTE;   d.pkind = KIND_VALUE; d.begin_next = 1'b1; end
        "/":     begin d.mode = MODE_SLASH;   d.pkind = KIND_VALUE; end
        "t":     begin d.mode = MODE_TRUE;    d.pkind = KIND_VALUE; end
        "f":     begin d.mode = MODE_FALSE;   d.pkind = KIND_VALUE; end
        default: begin d.mode = MODE_VALUE;   d.pkind = KIND_VALUE; end
      endcase
    end
    return d;
  endfunction

  lex_mode_t   mode, mode_next, mode_step;
  logic [15:0] scan_position, scan_position_next;
  logic [15:0] token_begin, token_begin_next, begin_step;
  logic [4:0]  pending_kind, pending_kind_next, pkind_step;
  logic [2:0]  literal_match_count, literal_match_count_next, lmc_step;
  logic        overflow_seen, overflow_seen_next;

  logic [15:0] off, nxt;
  logic        ovf_now;
  logic        relex;
  emit_t       close;
  idle_t       idle;
  logic        is_false;
  logic [2:0]  lit_len;

  assign ovf_now  = overflow_seen | (scan_position >= POS_LIMIT);
  assign off      = (scan_position >= POS_LIMIT) ? POS_LIMIT : scan_position;
  assign nxt      = (off < POS_LIMIT) ? (off + 16'd1) : POS_LIMIT;
  assign idle     = idle_decode(text_byte);
  assign is_false = (mode == MODE_FALSE);
  assign lit_len  = is_false ? 3'd4 : 3'd3;

  // next state
  always_comb begin
    close      = '0;
    relex      = 1'b0;
    mode_step  = mode;
    pkind_step = pending_kind;
    begin_step = token_begin;
    lmc_step   = literal_match_count;

    if (mode inside {[MODE_BANG:MODE_TILDE]}) begin
      if (text_byte == op_second(mode)) begin
        close = '{valid: 1'b1, kind: op_kind2(mode), first: token_begin, stop: nxt};
      end else begin
        close = '{valid: 1'b1, kind: pending_kind, first: token_begin, stop: off};
        relex = 1'b1;
      end
      mode_step = MODE_IDLE;
    end else begin
      case (mode)
        MODE_DOLLAR: begin
          if (text_byte == "=") begin
            close     = '{valid: 1'b1, kind: KIND_ENDS, first: token_begin, stop: nxt};
            mode_step = MODE_IDLE;
          end else if (text_byte == "$") begin
            close     = '{valid: 1'b1, kind: KIND_PID, first: token_begin, stop: nxt};
            mode_step = MODE_IDLE;
          end else if (text_byte == "{") begin
            mode_step  = MODE_BRACE;
            begin_step = nxt;
          end else if (is_name(text_byte)) begin
            mode_step  = MODE_NAME;
            begin_step = off;
          end else begin
            close = '{valid: 1'b1, kind: KIND_NAME, first: off, stop: off};
            relex = 1'b1;
          end
        end
        MODE_NAME: begin
          if (!is_name(text_byte)) begin
            close = '{valid: 1'b1, kind: KIND_NAME, first: token_begin, stop: off};
            relex = 1'b1;
          end
        end
        MODE_BRACE: begin
          if (text_byte == "}") begin
            close     = '{valid: 1'b1, kind: KIND_NAME, first: token_begin, stop: off};
            mode_step = MODE_IDLE;
          end
        end
        MODE_QUOTE: begin
          if (text_byte == "'") begin
            close     = '{valid: 1'b1, kind: KIND_VALUE, first: token_begin, stop: off};
            mode_step = MODE_IDLE;
          end
        end
        MODE_DIGITS: begin
          if (!is_digit(text_byte)) begin
            close = '{valid: 1'b1, kind: KIND_VALUE, first: token_begin, stop: off};
            relex = 1'b1;
          end
        end
        MODE_SLASH, MODE_TRUE, MODE_FALSE, MODE_VALUE: begin
          if ((mode == MODE_SLASH) && (is_digit(text_byte) || is_space(text_byte))) begin
            close = '{valid: 1'b1, kind: KIND_DIV, first: token_begin, stop: off};
            relex = 1'b1;
          end else if (((mode == MODE_TRUE) || (mode == MODE_FALSE))
                       && (literal_match_count < lit_len)
                       && (text_byte == lit_char(is_false, literal_match_count))) begin
            lmc_step = literal_match_count + 3'd1;
            if (lmc_step == lit_len) begin
              close     = '{valid: 1'b1, kind: KIND_VALUE, first: token_begin, stop: nxt};
              mode_step = MODE_IDLE;
            end
          end else begin
            mode_step = MODE_VALUE;
            lmc_step  = 3'd0;
            if (text_byte == "(") begin
              close = '{valid: 1'b1, kind: KIND_FN, first: token_begin, stop: off};
              relex = 1'b1;
            end else if ((text_byte == ")") || (text_byte == ",") || !is_graph(text_byte)) begin
              close = '{valid: 1'b1, kind: KIND_VALUE, first: token_begin, stop: off};
              relex = 1'b1;
            end
          end
        end
        default: begin
          relex = 1'b1;
        end
      endcase
    end

    if (mode_step == MODE_IDLE) begin
      pkind_step = KIND_END;
      lmc_step   = 3'd0;
    end

    if (relex) begin
      mode_step  = idle.mode;
      pkind_step = idle.pkind;
      lmc_step   = 3'd0;
      if (idle.mode != MODE_IDLE) begin
        begin_step = idle.begin_next ? nxt : off;
      end
    end

    if (end_of_text) begin
      mode_next                = MODE_IDLE;
      scan_position_next       = 16'd0;
      token_begin_next         = 16'd0;
      pending_kind_next        = KIND_END;
      literal_match_count_next = 3'd0;
      overflow_seen_next       = 1'b0;
    end else begin
      mode_next                = mode_step;
      scan_position_next       = nxt;
      token_begin_next         = begin_step;
      pending_kind_next        = pkind_step;
      literal_match_count_next = lmc_step;
      overflow_seen_next       = ovf_now;
    end
  end

  // outputs
  emit_t relex_emit, flush_emit, end_emit, first_emit, second_emit;
  logic  second_valid;

  always_comb begin
    relex_emit = '{valid: relex & idle.emit, kind: idle.kind, first: off, stop: nxt};
    if (mode_step == MODE_DOLLAR) begin
      flush_emit = '{valid: end_of_text, kind: KIND_NAME, first: nxt, stop: nxt};
    end else begin
      flush_emit = '{valid: end_of_text & (mode_step != MODE_IDLE), kind: pkind_step,
                     first: begin_step, stop: nxt};
    end
    end_emit = '{valid: end_of_text & ~close.valid & ~relex_emit.valid & ~flush_emit.valid,
                 kind: KIND_END, first: nxt, stop: nxt};

    if (close.valid) begin
      first_emit = close;
    end else if (relex_emit.valid) begin
      first_emit = relex_emit;
    end else if (flush_emit.valid) begin
      first_emit = flush_emit;
    end else begin
      first_emit = end_emit;
    end

    if (close.valid && relex_emit.valid) begin
      second_emit = relex_emit;
    end else begin
      second_emit = flush_emit;
    end
    second_valid = (close.valid & (relex_emit.valid | flush_emit.valid))
                 | (relex_emit.valid & flush_emit.valid);

    push_count = first_emit.valid ? (second_valid ? 2'd2 : 2'd1) : 2'd0;

    slot0 = '{kind: first_emit.kind, start: first_emit.first,
              length: span(first_emit.first, first_emit.stop),
              last: ~second_valid, overflow: ovf_now};
    slot1 = '{kind: second_emit.kind, start: second_emit.first,
              length: span(second_emit.first, second_emit.stop),
              last: 1'b1, overflow: ovf_now};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= MODE_IDLE;
      scan_position       <= 16'd0;
      token_begin         <= 16'd0;
      pending_kind        <= KIND_END;
      literal_match_count <= 3'd0;
      overflow_seen       <= 1'b0;
    end else if (advance) begin
      mode                <= mode_next;
      scan_position       <= scan_position_next;
      token_begin         <= token_begin_next;
      pending_kind        <= pending_kind_next;
      literal_match_count <= literal_match_count_next;
      overflow_seen       <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/etl_queue.sv
// ----------------------------------------------------------------------------
// etl_queue
// Small token queue; takes up to two tokens per cycle, releases one.
// ----------------------------------------------------------------------------
`default_nettype none

module etl_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [1:0]          push_count,
  input  wire etl_pkg::result_t    push0,
  input  wire etl_pkg::result_t    push1,
  input  wire logic                pop,
  output etl_pkg::result_t         head,
  output logic [2:0]               count
);
  import etl_pkg::*;

  result_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W-1:0] wr_ptr_next, rd_ptr_next;
  logic [2:0]             count_next;

  assign head        = entries[rd_ptr];
  assign wr_ptr_next = wr_ptr + QUEUE_PTR_W'(push_count);
  assign rd_ptr_next = rd_ptr + QUEUE_PTR_W'(pop);
  assign count_next  = count + {1'b0, push_count} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + QUEUE_PTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/expression_token_lexer_core.sv
// ----------------------------------------------------------------------------
// expression_token_lexer_core
// Streams expression text bytes in and emits tokens with kind, start offset
// and length.
//
//   channel   signals                                  dir   per transfer
//   byte      byte_valid/byte_stall, text_byte,        in    one text byte
//             end_of_text
//   token     token_valid/token_stall, token_kind,     out   one token
//             token_start, token_length, last_result,
//             position_overflow
//
// One byte per cycle while byte_stall is low. Each byte enters a holding
// register; when the queue has room the lexer step resolves it, writing
// up to two tokens to a 4-entry queue, drained one token at a time by the
// single token port. Reset returns to between-token state at offset 0.
// byte_stall rises while a byte waits and the queue has no room for two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_token_lexer_core #(
  parameter longint unsigned MAX_TEXT_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_text,
  output logic             token_valid,
  input  wire logic        token_stall,
  output logic [4:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic             last_result,
  output logic             position_overflow
);
  import etl_pkg::*;

  localparam logic [15:0] POS_LIMIT =
    (MAX_TEXT_BYTES > 64'd65535) ? 16'hFFFF : 16'(MAX_TEXT_BYTES);

  logic       hold_valid, hold_valid_next;
  logic [7:0] hold_byte;
  logic       hold_eot;
  logic       accept, advance, room, pop;
  logic [1:0] push_count;
  logic [2:0] q_count;
  result_t    slot0, slot1, head;

  assign room       = q_count <= 3'(QUEUE_DEPTH - 2);
  assign advance    = hold_valid & room;
  assign byte_stall = hold_valid & ~room;
  assign accept     = byte_valid & ~byte_stall;
  assign hold_valid_next = accept | (hold_valid & ~advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= text_byte;
      hold_eot  <= end_of_text;
    end
  end

  etl_step #(
    .POS_LIMIT (POS_LIMIT)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .text_byte   (hold_byte),
    .end_of_text (hold_eot),
    .push_count  (push_count),
    .slot0       (slot0),
    .slot1       (slot1)
  );

  etl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (advance ? push_count : 2'd0),
    .push0      (slot0),
    .push1      (slot1),
    .pop        (pop),
    .head       (head),
    .count      (q_count)
  );

  assign token_valid       = q_count != 3'd0;
  assign pop               = token_valid & ~token_stall;
  assign token_kind        = head.kind;
  assign token_start       = head.start;
  assign token_length      = head.length;
  assign last_result       = head.last;
  assign position_overflow = head.overflow;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= 3'(QUEUE_DEPTH))
    else $error("token queue over capacity");

  a_eot_result: assert property (@(posedge clk) disable iff (rst)
    (advance && hold_eot) |-> (push_count != 2'd0))
    else $error("end of text gave no token");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (advance && push_count == 2'd2) |-> (!slot0.last && slot1.last))
    else $error("last mark misplaced on two-token byte");

endmodule

`default_nettype wire

FILE: bench/expression_token_lexer_core_tb.sv
// ----------------------------------------------------------------------------
// expression_token_lexer_core_tb
// Feeds expression text bytes through the lexer core and checks every token
// transfer against a cycle-free model of the lexer kept in the bench. Covers
// directed corner texts, random well-formed and broken texts, random idling
// on both channels, a long receiver hold-off and drained pauses between
// phases.
// ----------------------------------------------------------------------------
module expression_token_lexer_core_tb;
  import etl_pkg::*;

  localparam longint unsigned TEXT_LIMIT_BYTES = 65536;
  localparam logic [15:0] POS_LIMIT =
    (TEXT_LIMIT_BYTES > 64'd65535) ? 16'hFFFF : 16'(TEXT_LIMIT_BYTES);

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  text_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_result;
  logic        position_overflow;

  text_item_t  text_bytes_pending[$];
  result_t     expected_tokens[$];
  result_t     step_tokens[$];
  logic [7:0]  text_buf[$];

  lex_mode_t   lx_mode;
  logic [15:0] lx_pos;
  logic [15:0] lx_begin;
  logic [4:0]  lx_kind;
  logic [2:0]  lx_match;
  logic        lx_ovf;

  int          mismatches = 0;
  int          idle_pct = 0;
  bit          quiet = 1'b0;
  bit          hold_armed = 1'b0;
  logic        rx_hold = 1'b0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  text_item_t  tx_item;
  result_t     want;

  expression_token_lexer_core #(
    .MAX_TEXT_BYTES(TEXT_LIMIT_BYTES)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .text_byte        (text_byte),
    .end_of_text      (end_of_text),
    .token_valid      (token_valid),
    .token_stall      (token_stall),
    .token_kind       (token_kind),
    .token_start      (token_start),
    .token_length     (token_length),
    .last_result      (last_result),
    .position_overflow(position_overflow)
  );

  function automatic bit ws_byte(logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit digit_byte(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit print_byte(logic [7:0] b);
    return b >= 8'd33 && b <= 8'd126;
  endfunction

  function automatic bit word_byte(logic [7:0] b);
    return digit_byte(b) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
  endfunction

  function automatic logic [7:0] op_follow(lex_mode_t m);
    if (m == MODE_AMP) return "&";
    if (m == MODE_PIPE) return "|";
    return "=";
  endfunction

  function automatic logic [4:0] op_pair(lex_mode_t m);
    case (m)
      MODE_BANG:    return KIND_NE;
      MODE_AMP:     return KIND_AND;
      MODE_STAR:    return KIND_CONTAINS;
      MODE_LESS:    return KIND_LE;
      MODE_EQUAL:   return KIND_EQ;
      MODE_GREATER: return KIND_GE;
      MODE_CARET:   return KIND_STARTS;
      MODE_PIPE:    return KIND_OR;
      MODE_TILDE:   return KIND_PRESENT;
      default:      return KIND_ERROR;
    endcase
  endfunction

  function automatic logic [7:0] word_letter(bit is_false, logic [2:0] i);
    string w;
    if (is_false) w = "alse";
    else w = "rue";
    return (i < w.len()) ? w[i] : 8'd0;
  endfunction

  function automatic void put_token(logic [4:0] kind, logic [15:0] first, logic [15:0] stop);
    result_t r;
    if (step_tokens.size() >= 2) return;
    r.kind = kind;
    r.start = first;
    r.length = (stop >= first) ? stop - first : 16'd0;
    r.last = 1'b0;
    r.overflow = lx_ovf;
    step_tokens.push_back(r);
  endfunction

  function automatic void go_idle();
    lx_mode = MODE_IDLE;
    lx_kind = KIND_END;
    lx_match = 3'd0;
  endfunction

  function automatic void reset_lexer();
    go_idle();
    lx_pos = 16'd0;
    lx_begin = 16'd0;
    lx_ovf = 1'b0;
  endfunction

  function automatic void enter_mode(lex_mode_t m, logic [4:0] kind, logic [15:0] at);
    lx_mode = m;
    lx_kind = kind;
    lx_begin = at;
    lx_match = 3'd0;
  endfunction

  function automatic void lex_idle(logic [7:0] b, logic [15:0] off, logic [15:0] nxt);
    if (ws_byte(b)) return;
    if (!print_byte(b)) begin
      put_token(KIND_ERROR, off, nxt);
      return;
    end
    if (digit_byte(b)) begin
      enter_mode(MODE_DIGITS, KIND_VALUE, off);
      return;
    end
    case (b)
      "!":     enter_mode(MODE_BANG, KIND_NOT, off);
      "$":     enter_mode(MODE_DOLLAR, KIND_NAME, off);
      "%":     put_token(KIND_MOD, off, nxt);
      "(":     put_token(KIND_LPAREN, off, nxt);
      ")":     put_token(KIND_RPAREN, off, nxt);
      "+":     put_token(KIND_PLUS, off, nxt);
      ",":     put_token(KIND_COMMA, off, nxt);
      "-":     put_token(KIND_MINUS, off, nxt);
      "&":     enter_mode(MODE_AMP, KIND_ERROR, off);
      "*":     enter_mode(MODE_STAR, KIND_MULT, off);
      "<":     enter_mode(MODE_LESS, KIND_LT, off);
      "=":     enter_mode(MODE_EQUAL, KIND_EQ, off);
      ">":     enter_mode(MODE_GREATER, KIND_GT, off);
      "^":     enter_mode(MODE_CARET, KIND_ERROR, off);
      "|":     enter_mode(MODE_PIPE, KIND_ERROR, off);
      "~":     enter_mode(MODE_TILDE, KIND_ERROR, off);
      "'":     enter_mode(MODE_QUOTE, KIND_VALUE, nxt);
      "/":     enter_mode(MODE_SLASH, KIND_VALUE, off);
      "t":     enter_mode(MODE_TRUE, KIND_VALUE, off);
      "f":     enter_mode(MODE_FALSE, KIND_VALUE, off);
      default: enter_mode(MODE_VALUE, KIND_VALUE, off);
    endcase
  endfunction

  function automatic void close_relex(logic [4:0] kind, logic [7:0] b, logic [15:0] off,
                                      logic [15:0] nxt);
    put_token(kind, lx_begin, off);
    go_idle();
    lex_idle(b, off, nxt);
  endfunction

  function automatic void lex_value(logic [7:0] b, logic [15:0] off, logic [15:0] nxt);
    if (b == "(") begin
      close_relex(KIND_FN, b, off, nxt);
    end else if (b == ")" || b == "," || !print_byte(b)) begin
      close_relex(KIND_VALUE, b, off, nxt);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] b, logic [15:0] off, logic [15:0] nxt);
    logic [2:0] need;
    if (lx_mode >= MODE_BANG && lx_mode <= MODE_TILDE) begin
      if (b == op_follow(lx_mode)) begin
        put_token(op_pair(lx_mode), lx_begin, nxt);
        go_idle();
      end else begin
        close_relex(lx_kind, b, off, nxt);
      end
      return;
    end
    case (lx_mode)
      MODE_DOLLAR: begin
        if (b == "=") begin
          put_token(KIND_ENDS, lx_begin, nxt);
          go_idle();
        end else if (b == "$") begin
          put_token(KIND_PID, lx_begin, nxt);
          go_idle();
        end else if (b == "{") begin
          enter_mode(MODE_BRACE, KIND_NAME, nxt);
        end else if (word_byte(b)) begin
          enter_mode(MODE_NAME, KIND_NAME, off);
        end else begin
          put_token(KIND_NAME, off, off);
          go_idle();
          lex_idle(b, off, nxt);
        end
      end
      MODE_NAME: begin
        if (!word_byte(b)) close_relex(KIND_NAME, b, off, nxt);
      end
      MODE_BRACE: begin
        if (b == "}") begin
          put_token(KIND_NAME, lx_begin, off);
          go_idle();
        end
      end
      MODE_QUOTE: begin
        if (b == "'") begin
          put_token(KIND_VALUE, lx_begin, off);
          go_idle();
        end
      end
      MODE_DIGITS: begin
        if (!digit_byte(b)) close_relex(KIND_VALUE, b, off, nxt);
      end
      MODE_SLASH: begin
        if (digit_byte(b) || ws_byte(b)) begin
          close_relex(KIND_DIV, b, off, nxt);
        end else begin
          lx_mode = MODE_VALUE;
          lex_value(b, off, nxt);
        end
      end
      MODE_TRUE, MODE_FALSE: begin
        need = (lx_mode == MODE_TRUE) ? 3'd3 : 3'd4;
        if (lx_match < need && b == word_letter(lx_mode == MODE_FALSE, lx_match)) begin
          lx_match = lx_match + 3'd1;
          if (lx_match == need) begin
            put_token(KIND_VALUE, lx_begin, nxt);
            go_idle();
          end
        end else begin
          lx_mode = MODE_VALUE;
          lx_match = 3'd0;
          lex_value(b, off, nxt);
        end
      end
      MODE_VALUE: begin
        lex_value(b, off, nxt);
      end
      default: begin
        go_idle();
        lex_idle(b, off, nxt);
      end
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] b, logic eot);
    logic [15:0] off;
    logic [15:0] nxt;
    step_tokens.delete();
    off = lx_pos;
    if (off >= POS_LIMIT) begin
      off = POS_LIMIT;
      lx_ovf = 1'b1;
    end
    nxt = (off < POS_LIMIT) ? off + 16'd1 : POS_LIMIT;
    lex_byte(b, off, nxt);
    lx_pos = nxt;
    if (eot) begin
      if (lx_mode == MODE_DOLLAR) begin
        put_token(KIND_NAME, nxt, nxt);
      end else if (lx_mode != MODE_IDLE) begin
        put_token(lx_kind, lx_begin, nxt);
      end
      if (step_tokens.size() == 0) put_token(KIND_END, nxt, nxt);
      reset_lexer();
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic void check_field(string field, logic [15:0] exp_v, logic [15:0] got);
    if (got !== exp_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, got);
      mismatches++;
    end
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void add_piece();
    string singles;
    string firsts;
    string w;
    string word_chars;
    logic [7:0] c;
    int n;
    singles = "!&*<=>^|~%()+,-";
    firsts = "!&*<=>^|~";
    word_chars = "abzAZ_09xQ";
    case ($urandom_range(0, 13))
      0: text_buf.push_back(singles[$urandom_range(0, singles.len() - 1)]);
      1: begin
        c = firsts[$urandom_range(0, firsts.len() - 1)];
        text_buf.push_back(c);
        if ((c == "&" || c == "|") && $urandom_range(0, 1)) text_buf.push_back(c);
        else text_buf.push_back("=");
      end
      2: begin
        repeat ($urandom_range(1, 6)) text_buf.push_back(8'("0" + $urandom_range(0, 9)));
      end
      3: begin
        text_buf.push_back("'");
        repeat ($urandom_range(0, 5)) begin
          c = 8'($urandom_range(0, 255));
          text_buf.push_back(c == "'" ? "q" : c);
        end
        text_buf.push_back("'");
      end
      4: add_str($urandom_range(0, 1) ? "true" : "false");
      5: begin
        w = $urandom_range(0, 1) ? "true" : "false";
        n = $urandom_range(1, w.len() - 1);
        for (int i = 0; i < n; i++) text_buf.push_back(w[i]);
        text_buf.push_back(8'("a" + $urandom_range(0, 25)));
      end
      6: begin
        text_buf.push_back("$");
        repeat ($urandom_range(1, 4))
          text_buf.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
      end
      7: begin
        add_str("${");
        repeat ($urandom_range(0, 4)) begin
          c = 8'($urandom_range(0, 255));
          text_buf.push_back(c == "}" ? "n" : c);
        end
        text_buf.push_back("}");
      end
      8: begin
        case ($urandom_range(0, 2))
          0:       add_str("$$");
          1:       add_str("$=");
          default: add_str("$");
        endcase
      end
      9: begin
        repeat ($urandom_range(1, 6)) text_buf.push_back(8'("a" + $urandom_range(0, 25)));
        if ($urandom_range(0, 2) == 0) text_buf.push_back("(");
      end
      10: begin
        text_buf.push_back("/");
        case ($urandom_range(0, 3))
          0:       text_buf.push_back(8'("0" + $urandom_range(0, 9)));
          1:       text_buf.push_back(" ");
          2:       text_buf.push_back(8'("a" + $urandom_range(0, 25)));
          default: text_buf.push_back("/");
        endcase
      end
      11: begin
        repeat ($urandom_range(1, 3)) begin
          n = $urandom_range(8, 13);
          text_buf.push_back(n == 8 ? 8'd32 : 8'(n));
        end
      end
      12: begin
        case ($urandom_range(0, 2))
          0:       text_buf.push_back(8'($urandom_range(0, 8)));
          1:       text_buf.push_back(8'($urandom_range(14, 31)));
          default: text_buf.push_back(8'($urandom_range(127, 255)));
        endcase
      end
      default: text_buf.push_back(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 1)) text_buf.push_back(" ");
  endfunction

  function automatic void queue_text();
    text_item_t it;
    foreach (text_buf[i]) begin
      it.b = text_buf[i];
      it.eot = (i == text_buf.size() - 1);
      text_bytes_pending.push_back(it);
    end
    text_buf.delete();
  endfunction

  function automatic void queue_random_texts(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      repeat ($urandom_range(1, 8)) add_piece();
      if ($urandom_range(0, 3) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
      sent += text_buf.size();
      queue_text();
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (text_bytes_pending.size() != 0 || byte_valid || expected_tokens.size() != 0);
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  // driver: offer bytes, predict on each transfer
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      tx_gap = 0;
      reset_lexer();
    end else begin
      if (byte_valid && !byte_stall) predict_tokens(text_byte, end_of_text);
      if (!byte_valid || !byte_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          byte_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
          tx_gap = $urandom_range(0, 13);
          byte_valid <= 1'b0;
        end else if (text_bytes_pending.size() > 0) begin
          tx_item = text_bytes_pending.pop_front();
          byte_valid <= 1'b1;
          text_byte <= tx_item.b;
          end_of_text <= tx_item.eot;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each token transfer, drive random stall
  always @(posedge clk) begin
    if (rst) begin
      token_stall <= 1'b0;
      rx_gap = 0;
    end else begin
      if (token_valid && !token_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("token transfer with nothing expected: kind %0d start %0d length %0d",
                 token_kind, token_start, token_length);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", want.kind, token_kind);
          check_field("token_start", want.start, token_start);
          check_field("token_length", want.length, token_length);
          check_field("last_result", want.last, last_result);
          check_field("position_overflow", want.overflow, position_overflow);
        end
      end
      if (rx_gap > 0) rx_gap--;
      else if (!quiet && $urandom_range(0, 99) < idle_pct) rx_gap = $urandom_range(1, 14);
      token_stall <= rx_hold || (rx_gap > 0);
    end
  end

  // hold the token side off for a long stretch
  initial begin
    wait (hold_armed);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 25;
    text_buf.push_back(8'h00);
    queue_text();
    text_buf.push_back(8'hFF);
    queue_text();
    add_str(" ");
    queue_text();
    add_str("&|^~");
    queue_text();
    add_str("/1 /x /");
    queue_text();
    add_str("trues fal)");
    queue_text();
    add_str("$ $x ${");
    queue_text();
    add_str("'ab");
    queue_text();
    wait_drained();

    idle_pct = 30;
    hold_armed = 1'b1;
    queue_random_texts(1000);
    wait_drained();

    idle_pct = 30;
    queue_random_texts(700);
    while (text_bytes_pending.size() != 0) @(negedge clk);
    quiet = 1'b1;
    queue_random_texts(300);
    wait_drained();

    repeat (32) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/etl_pkg.sv
rtl/core/etl_step.sv
rtl/core/etl_queue.sv
rtl/core/expression_token_lexer_core.sv
bench/expression_token_lexer_core_tb.sv
